[design/rau_pkg.sv]
package rau_pkg;

  localparam int unsigned OP_W      = 3;
  localparam int unsigned NUM_W     = 32;
  localparam int unsigned DEN_W     = 31;
  localparam int unsigned RES_NUM_W = 64;
  localparam int unsigned RES_DEN_W = 63;

  localparam logic [OP_W-1:0] OP_ADD = 3'd0;
  localparam logic [OP_W-1:0] OP_SUB = 3'd1;
  localparam logic [OP_W-1:0] OP_MUL = 3'd2;
  localparam logic [OP_W-1:0] OP_DIV = 3'd3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_ACC,
    ST_FIX,
    ST_GCD,
    ST_DIVN,
    ST_DIVD,
    ST_OUT
  } rau_state_t;

endpackage

[design/rau_req_if.sv]
interface rau_req_if import rau_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [OP_W-1:0]         operation;
  logic signed [NUM_W-1:0] a_num;
  logic [DEN_W-1:0]        a_den;
  logic signed [NUM_W-1:0] b_num;
  logic [DEN_W-1:0]        b_den;

  modport source (output valid, operation, a_num, a_den, b_num, b_den, input ready);
  modport sink   (input valid, operation, a_num, a_den, b_num, b_den, output ready);
endinterface

[design/rau_rsp_if.sv]
interface rau_rsp_if import rau_pkg::*; ();
  logic                        valid;
  logic                        ready;
  logic signed [RES_NUM_W-1:0] res_num;
  logic [RES_DEN_W-1:0]        res_den;
  logic                        den_was_zero;

  modport source (output valid, res_num, res_den, den_was_zero, input ready);
  modport sink   (input valid, res_num, res_den, den_was_zero, output ready);
endinterface

[design/rational_arithmetic_unit.sv]
// Sequence after the input transfer: product passes on one shared 33x33 multiplier
// (three passes; none for normalize), a fixup state, binary gcd steps, then two restoring
// divides of 64 steps each, first the numerator and then the denominator.
// Throughput: one item in flight; ready returns the cycle after the result transfer.
// rst (synchronous) returns the sequencer to idle; no result pending after reset.
module rational_arithmetic_unit import rau_pkg::*; #(
  parameter int unsigned OPERAND_BITS = 32
) (
  input  logic       clk,
  input  logic       rst,
  rau_req_if.sink    req,
  rau_rsp_if.source  rsp
);

  rau_state_t state, state_next;

  logic [OP_W-1:0]    op;
  logic signed [32:0] an, ad, bn, bd;
  logic [1:0]         step;
  logic signed [63:0] prod;
  logic signed [63:0] n;
  logic [63:0]        d;
  logic               flag;
  logic               neg;
  logic [63:0]        mag;
  logic [63:0]        u, v;
  logic [5:0]         k;
  logic [63:0]        g;
  logic [63:0]        q, rem;
  logic [5:0]         cnt;
  logic [63:0]        qn;
  logic signed [RES_NUM_W-1:0] res_num;
  logic [RES_DEN_W-1:0]        res_den;

  logic signed [32:0] mul_a, mul_b, bn_abs;
  logic signed [65:0] mul_p;
  logic [64:0]        diff;
  logic [63:0]        absd;
  logic [64:0]        dcur, dsub;
  logic [63:0]        rem_next, q_next;
  logic               gcd_done, div_last, nrm;
  logic [63:0]        d_fix;

  assign nrm      = !(req.operation == OP_ADD || req.operation == OP_SUB ||
                      req.operation == OP_MUL || req.operation == OP_DIV);
  assign gcd_done = (u == 64'd0);
  assign div_last = (cnt == 6'd63);

  always_comb begin
    bn_abs = bn[32] ? -bn : bn;
    mul_a  = an;
    mul_b  = bd;
    case (step)
      2'd0: begin
        mul_a = an;
        mul_b = (op == OP_MUL) ? bn : bd;
      end
      2'd1: begin
        mul_a = bn;
        mul_b = ad;
      end
      default: begin
        mul_a = ad;
        mul_b = (op == OP_DIV) ? bn_abs : bd;
      end
    endcase
    mul_p = mul_a * mul_b;
  end

  always_comb begin
    diff = {1'b0, u} - {1'b0, v};
    absd = diff[64] ? (64'd0 - diff[63:0]) : diff[63:0];
    dcur = {rem, q[63]};
    dsub = dcur - {1'b0, g};
    if (!dsub[64]) begin
      rem_next = dsub[63:0];
      q_next   = {q[62:0], 1'b1};
    end else begin
      rem_next = dcur[63:0];
      q_next   = {q[62:0], 1'b0};
    end
    d_fix = (d == 64'd0 || n == 64'sd0) ? 64'd1 : d;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (req.valid) state_next = nrm ? ST_FIX : ST_MUL;
      ST_MUL:  state_next = ST_ACC;
      ST_ACC:  state_next = (step == 2'd2) ? ST_FIX : ST_MUL;
      ST_FIX:  state_next = ST_GCD;
      ST_GCD:  if (gcd_done) state_next = ST_DIVN;
      ST_DIVN: if (div_last) state_next = ST_DIVD;
      ST_DIVD: if (div_last) state_next = ST_OUT;
      ST_OUT:  if (rsp.ready) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    req.ready = (state == ST_IDLE);
    rsp.valid = (state == ST_OUT);
  end

  assign rsp.res_num      = res_num;
  assign rsp.res_den      = res_den;
  assign rsp.den_was_zero = flag;

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        op   <= req.operation;
        an   <= 33'($signed(req.a_num[OPERAND_BITS-1:0]));
        ad   <= 33'(req.a_den[OPERAND_BITS-2:0]);
        bn   <= 33'($signed(req.b_num[OPERAND_BITS-1:0]));
        bd   <= 33'(req.b_den[OPERAND_BITS-2:0]);
        n    <= 64'($signed(req.a_num[OPERAND_BITS-1:0]));
        d    <= 64'(req.a_den[OPERAND_BITS-2:0]);
        step <= 2'd0;
      end
      ST_MUL: prod <= mul_p[63:0];
      ST_ACC: begin
        case (step)
          2'd0: n <= (op == OP_DIV && bn[32]) ? -prod : prod;
          2'd1: begin
            if (op == OP_ADD)      n <= n + prod;
            else if (op == OP_SUB) n <= n - prod;
          end
          default: d <= prod;
        endcase
        step <= step + 2'd1;
      end
      ST_FIX: begin
        flag <= (d == 64'd0);
        neg  <= n[63];
        mag  <= n[63] ? (64'd0 - n) : n;
        u    <= n[63] ? (64'd0 - n) : n;
        v    <= d_fix;
        d    <= d_fix;
        k    <= 6'd0;
      end
      ST_GCD: begin
        if (gcd_done) begin
          g   <= v << k;
          q   <= mag;
          rem <= 64'd0;
          cnt <= 6'd0;
        end else if (!u[0] && !v[0]) begin
          u <= u >> 1;
          v <= v >> 1;
          k <= k + 6'd1;
        end else if (!u[0]) begin
          u <= u >> 1;
        end else if (!v[0]) begin
          v <= v >> 1;
        end else if (!diff[64]) begin
          u <= absd >> 1;
        end else begin
          v <= absd >> 1;
        end
      end
      ST_DIVN: begin
        cnt <= cnt + 6'd1;
        if (div_last) begin
          qn  <= q_next;
          q   <= d;
          rem <= 64'd0;
        end else begin
          q   <= q_next;
          rem <= rem_next;
        end
      end
      ST_DIVD: begin
        cnt <= cnt + 6'd1;
        q   <= q_next;
        rem <= rem_next;
        if (div_last) begin
          res_den <= q_next[RES_DEN_W-1:0];
          res_num <= neg ? (64'd0 - qn) : qn;
        end
      end
      default: ;
    endcase
  end

`ifndef SYNTH
  a_busy_no_out: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> !req.ready) else $error("result shown while accepting");
  a_den_nonzero: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> (rsp.res_den != '0)) else $error("zero result denominator");
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready) |=> !req.ready) else $error("ready after transfer");
`endif

endmodule

[tb/rational_arithmetic_unit_tb.sv]
module rational_arithmetic_unit_tb import rau_pkg::*; ();

  localparam logic [OP_W-1:0] OP_NORM = 3'd4;
  localparam int unsigned WATCHDOG_LIMIT = 20000;
  localparam int unsigned N_RANDOM = 1700;

  typedef struct packed {
    logic [OP_W-1:0]         operation;
    logic signed [NUM_W-1:0] a_num;
    logic [DEN_W-1:0]        a_den;
    logic signed [NUM_W-1:0] b_num;
    logic [DEN_W-1:0]        b_den;
  } fraction_op_t;

  typedef struct packed {
    logic signed [RES_NUM_W-1:0] res_num;
    logic [RES_DEN_W-1:0]        res_den;
    logic                        den_was_zero;
  } fraction_res_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  rau_req_if req ();
  rau_rsp_if rsp ();

  rational_arithmetic_unit uut (
    .clk (clk),
    .rst (rst),
    .req (req.sink),
    .rsp (rsp.source)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  fraction_op_t  pending_ops[$];
  fraction_res_t expected_fracs[$];
  int unsigned   error_count = 0;
  int unsigned   idle_cycles = 0;
  int unsigned   cycle_count = 0;
  bit            hold_sender = 1'b0;

  function automatic logic [63:0] gcd64(logic [63:0] x, logic [63:0] y);
    logic [63:0] t;
    while (y != 64'd0) begin
      t = x % y;
      x = y;
      y = t;
    end
    return x;
  endfunction

  function automatic fraction_res_t reduce_fraction(fraction_op_t op);
    fraction_res_t r;
    logic signed [63:0] an, bn, n;
    logic [63:0] ad, bd, d, mag, g;
    logic neg;
    an = 64'(op.a_num);
    bn = 64'(op.b_num);
    ad = 64'(op.a_den);
    bd = 64'(op.b_den);
    r.den_was_zero = 1'b0;
    case (op.operation)
      OP_ADD: begin
        n = an * $signed(bd) + bn * $signed(ad);
        d = ad * bd;
      end
      OP_SUB: begin
        n = an * $signed(bd) - bn * $signed(ad);
        d = ad * bd;
      end
      OP_MUL: begin
        n = an * bn;
        d = ad * bd;
      end
      OP_DIV: begin
        n = an * $signed(bd);
        if (bn < 0) begin
          n = -n;
          d = ad * 64'(-bn);
        end else begin
          d = ad * 64'(bn);
        end
      end
      default: begin
        n = an;
        d = ad;
      end
    endcase
    if (d == 64'd0) begin
      d = 64'd1;
      r.den_was_zero = 1'b1;
    end
    if (n == 64'sd0) d = 64'd1;
    neg = n < 0;
    mag = neg ? 64'(0) - 64'(n) : 64'(n);
    g = gcd64(mag, d);
    mag = mag / g;
    d = d / g;
    r.res_num = neg ? 64'(0) - mag : mag;
    r.res_den = d[62:0];
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %0h expected %0h at cycle %0d", what, got, want,
             cycle_count);
    error_count++;
  endtask

  function automatic logic signed [31:0] rand_num();
    case ($urandom_range(0, 5))
      0: return $signed(32'h8000_0000 + $urandom_range(0, 3));
      1: return $signed(32'h7fff_ffff - $urandom_range(0, 3));
      2: return $signed($urandom_range(0, 40)) - 20;
      3: return $signed($urandom & 32'hffff) - 32768;
      default: return $signed($urandom);
    endcase
  endfunction

  function automatic logic [30:0] rand_den(bit allow_zero);
    logic [30:0] v;
    case ($urandom_range(0, 4))
      0: v = 31'(31'h7fff_ffff - $urandom_range(0, 3));
      1: v = 31'($urandom_range(0, 30));
      2: v = 31'($urandom & 32'hffff);
      default: v = 31'($urandom);
    endcase
    if (v == 31'd0 && !allow_zero) v = 31'd1;
    return v;
  endfunction

  function automatic fraction_op_t mk(logic [2:0] o, logic signed [31:0] an,
                                      logic [30:0] ad, logic signed [31:0] bn,
                                      logic [30:0] bd);
    fraction_op_t f;
    f.operation = o;
    f.a_num = an;
    f.a_den = ad;
    f.b_num = bn;
    f.b_den = bd;
    return f;
  endfunction

  // driver
  always @(posedge clk) begin
    if (rst) begin
      req.valid <= 1'b0;
      req.operation <= '0;
      req.a_num <= '0;
      req.a_den <= '0;
      req.b_num <= '0;
      req.b_den <= '0;
    end else if (!req.valid || req.ready) begin
      if (pending_ops.size() > 0 && !hold_sender &&
          (cycle_count % 4000 < 1500 || $urandom_range(0, 99) >= 19)) begin
        fraction_op_t f;
        f = pending_ops.pop_front();
        req.valid <= 1'b1;
        req.operation <= f.operation;
        req.a_num <= f.a_num;
        req.a_den <= f.a_den;
        req.b_num <= f.b_num;
        req.b_den <= f.b_den;
        expected_fracs.push_back(reduce_fraction(f));
      end else begin
        req.valid <= 1'b0;
      end
    end
  end

  // monitor and watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (rst) begin
      rsp.ready <= 1'b0;
    end else begin
      rsp.ready <= (cycle_count % 4000 < 1500) || ($urandom_range(0, 99) >= 19);
      if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("FAIL");
        $finish;
      end
      if (rsp.valid && rsp.ready) begin
        if (expected_fracs.size() == 0) begin
          report_mismatch("unexpected transfer", rsp.res_num, 64'd0);
        end else begin
          fraction_res_t e;
          e = expected_fracs.pop_front();
          if (rsp.res_num !== e.res_num) report_mismatch("res_num", rsp.res_num, e.res_num);
          if (rsp.res_den !== e.res_den)
            report_mismatch("res_den", 64'(rsp.res_den), 64'(e.res_den));
          if (rsp.den_was_zero !== e.den_was_zero)
            report_mismatch("den_was_zero", 64'(rsp.den_was_zero), 64'(e.den_was_zero));
        end
      end
    end
  end

  initial begin
    int unsigned k;
    logic [2:0] o;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    for (int op = 0; op < 5; op++) begin
      pending_ops.push_back(mk(3'(op), 32'sh7fffffff, 31'h7fffffff, 32'sh80000000,
                               31'h7fffffff));
      pending_ops.push_back(mk(3'(op), 32'sh80000000, 31'd1, 32'sh80000000, 31'd1));
    end
    pending_ops.push_back(mk(OP_NORM, 32'sd0, 31'd0, 32'sd5, 31'd3));
    pending_ops.push_back(mk(OP_NORM, -32'sd6, 31'd0, 32'sd5, 31'd3));
    pending_ops.push_back(mk(OP_NORM, -32'sd12, 31'd18, 32'sd0, 31'd1));
    pending_ops.push_back(mk(3'd5, 32'sd10, 31'd4, 32'sd1, 31'd1));
    pending_ops.push_back(mk(3'd6, -32'sd9, 31'd3, 32'sd1, 31'd1));
    pending_ops.push_back(mk(3'd7, 32'sd7, 31'd0, 32'sd1, 31'd1));
    pending_ops.push_back(mk(OP_DIV, 32'sd3, 31'd4, 32'sd0, 31'd5));
    pending_ops.push_back(mk(OP_DIV, 32'sd3, 31'd4, -32'sd6, 31'd5));
    pending_ops.push_back(mk(OP_ADD, 32'sd1, 31'd0, 32'sd1, 31'd2));
    pending_ops.push_back(mk(OP_SUB, 32'sd1, 31'd2, 32'sd1, 31'd2));
    pending_ops.push_back(mk(OP_MUL, 32'sd0, 31'd0, 32'sd3, 31'd4));
    pending_ops.push_back(mk(OP_ADD, -32'sd1, 31'd3, 32'sd1, 31'd6));

    for (k = 0; k < N_RANDOM; k++) begin
      o = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(5, 7)) : 3'($urandom_range(0, 4));
      pending_ops.push_back(mk(o, rand_num(), rand_den($urandom_range(0, 9) == 0),
                               rand_num(), rand_den($urandom_range(0, 9) == 0)));
      if (k == N_RANDOM / 2) begin
        wait (pending_ops.size() == 0);
        hold_sender = 1'b1;
        wait (expected_fracs.size() == 0);
        @(posedge clk);
        hold_sender = 1'b0;
      end
    end

    wait (pending_ops.size() == 0);
    wait (expected_fracs.size() == 0);
    repeat (400) @(posedge clk);
    if (error_count == 0 && expected_fracs.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
